// ----- rtl/bgr_pkg.sv -----
// Shared types and constants for the block glyph rectangle generator.
package bgr_pkg;

  // Shape codes reported with every result beat.
  typedef enum logic [3:0] {
    SHAPE_TEXT   = 4'd0,
    SHAPE_SPACE  = 4'd1,
    SHAPE_UPPER  = 4'd2,
    SHAPE_LOWER  = 4'd3,
    SHAPE_FULL   = 4'd4,
    SHAPE_LEFT   = 4'd5,
    SHAPE_RIGHT  = 4'd6,
    SHAPE_SQUARE = 4'd7,
    SHAPE_SMALL  = 4'd8
  } shape_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_BLOCK_WIDTH  = 2'd0,
    CFG_BLOCK_HEIGHT = 2'd1,
    CFG_PADDING      = 2'd2
  } cfg_index_t;

  // Character codes that are recognized.
  localparam logic [15:0] CODE_NUL         = 16'd0;
  localparam logic [15:0] CODE_TAB         = 16'd9;
  localparam logic [15:0] CODE_SPACE       = 16'd32;
  localparam logic [15:0] CODE_UPPER_HALF  = 16'd9600;
  localparam logic [15:0] CODE_LOWER_HALF  = 16'd9604;
  localparam logic [15:0] CODE_FULL_BLOCK  = 16'd9608;
  localparam logic [15:0] CODE_LEFT_HALF   = 16'd9612;
  localparam logic [15:0] CODE_RIGHT_HALF  = 16'd9616;
  localparam logic [15:0] CODE_LIGHT_SHADE = 16'd9617;
  localparam logic [15:0] CODE_MED_SHADE   = 16'd9618;
  localparam logic [15:0] CODE_DARK_SHADE  = 16'd9619;
  localparam logic [15:0] CODE_SQUARE      = 16'd9632;
  localparam logic [15:0] CODE_SMALL_SQ    = 16'd9642;

  // Opacity values.
  localparam logic [7:0] ALPHA_LIGHT  = 8'd90;
  localparam logic [7:0] ALPHA_MEDIUM = 8'd140;
  localparam logic [7:0] ALPHA_DARK   = 8'd190;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // Register values after reset.
  localparam logic [7:0] RESET_BLOCK_WIDTH  = 8'd7;
  localparam logic [7:0] RESET_BLOCK_HEIGHT = 8'd12;
  localparam logic [7:0] RESET_PADDING      = 8'd0;

  // Classification of one character code.
  typedef struct packed {
    shape_t     shape;
    logic [7:0] alpha;
  } glyph_class_t;

endpackage

// ----- rtl/block_glyph_rect_generator.sv -----
// Top level of the block glyph rectangle generator: stream ports, registers, assembly.
// A cell passes from the input beat through the input register and then the result register to the result beat.
// Throughput: one cell per clock while m_axis_tready is high; the path between the two registers is one
// row-by-height multiply followed by the offset adds.
// Reset clears both valid flags and loads width 7, height 12 and padding 0.
// Configuration writes are taken every cycle and apply to every cell not yet in the result register.
module block_glyph_rect_generator #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Input cells.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: char_code[15:0], cell_row[25:16], cell_col[33:26], zero fill [39:34].
  input  logic [39:0] s_axis_tdata,
  // Result rectangles.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: x_pos[18:0], y_pos[40:19], rect_width[51:41], rect_height[62:52],
  // alpha[70:63], zero fill [71].
  output logic [71:0] m_axis_tdata,
  // tuser: draw[0], shape[4:1].
  output logic [4:0]  m_axis_tuser,
  // Register writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import bgr_pkg::*;

  // Configuration registers.
  logic [7:0] block_width;
  logic [7:0] block_height;
  logic [7:0] padding;

  // Input stage.
  logic        in_valid;
  logic [33:0] in_data;
  logic        in_advance;

  // Result stage.
  logic        out_valid;
  logic [71:0] out_data;
  logic [4:0]  out_user;

  // Combinational results of the input stage.
  glyph_class_t       glyph;
  logic               draw;
  logic [18:0]        x_pos;
  logic signed [21:0] y_pos;
  logic [10:0]        rect_width;
  logic [10:0]        rect_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_width  <= RESET_BLOCK_WIDTH;
      block_height <= RESET_BLOCK_HEIGHT;
      padding      <= RESET_PADDING;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BLOCK_WIDTH:  block_width  <= cfg_data;
        CFG_BLOCK_HEIGHT: block_height <= cfg_data;
        CFG_PADDING:      padding      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The input stage moves forward whenever the result register is empty or
  // its beat is being taken this cycle. The input register takes a new beat
  // when it is empty or moving forward, so a waiting result does not stop
  // one more cell from being registered.
  assign in_advance    = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || in_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data <= s_axis_tdata[33:0];
    end
  end

  bgr_classify u_classify (
    .char_code (in_data[15:0]),
    .glyph     (glyph)
  );

  bgr_geometry #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_geometry (
    .shape        (glyph.shape),
    .cell_row     (in_data[25:16]),
    .cell_col     (in_data[33:26]),
    .block_width  (block_width),
    .block_height (block_height),
    .padding      (padding),
    .draw         (draw),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .rect_width   (rect_width),
    .rect_height  (rect_height)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance) begin
      out_data <= {1'b0, glyph.alpha, rect_height, rect_width, y_pos, x_pos};
      out_user <= {glyph.shape, draw};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;

`ifndef NO_ASSERTIONS
  // No result beat is offered in the cycle after reset.
  a_no_result_after_reset : assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A drawn rectangle always belongs to a block shape.
  a_draw_is_block : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tuser[4:1] != SHAPE_TEXT && m_axis_tuser[4:1] != SHAPE_SPACE))
    else $error("draw set for text or whitespace");

  // Nothing drawn means an all-zero rectangle.
  a_idle_geometry_zero : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[62:0] == 63'd0))
    else $error("rectangle not cleared for an undrawn cell");

  // Only shades carry partial opacity, and they are reported as full blocks.
  a_shade_is_full : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[70:63] != ALPHA_OPAQUE) |->
      (m_axis_tuser[4:1] == SHAPE_FULL))
    else $error("partial alpha on a shape other than full block");

  // A result that moved from the input stage lands in the result register.
  a_advance_fills_output : assert property (@(posedge clk) disable iff (rst)
    in_advance |=> m_axis_tvalid)
    else $error("advanced cell did not reach the result register");
`endif

endmodule

// ----- rtl/bgr_classify.sv -----
// Character code classifier: shape and opacity of one grid cell.
module bgr_classify (
  input  logic [15:0]          char_code,
  output bgr_pkg::glyph_class_t glyph
);
  import bgr_pkg::*;

  always_comb begin
    glyph.alpha = ALPHA_OPAQUE;
    unique case (char_code)
      CODE_NUL, CODE_TAB, CODE_SPACE: glyph.shape = SHAPE_SPACE;
      CODE_UPPER_HALF:  glyph.shape = SHAPE_UPPER;
      CODE_LOWER_HALF:  glyph.shape = SHAPE_LOWER;
      CODE_FULL_BLOCK:  glyph.shape = SHAPE_FULL;
      CODE_LEFT_HALF:   glyph.shape = SHAPE_LEFT;
      CODE_RIGHT_HALF:  glyph.shape = SHAPE_RIGHT;
      CODE_LIGHT_SHADE: begin
        glyph.shape = SHAPE_FULL;
        glyph.alpha = ALPHA_LIGHT;
      end
      CODE_MED_SHADE: begin
        glyph.shape = SHAPE_FULL;
        glyph.alpha = ALPHA_MEDIUM;
      end
      CODE_DARK_SHADE: begin
        glyph.shape = SHAPE_FULL;
        glyph.alpha = ALPHA_DARK;
      end
      CODE_SQUARE:   glyph.shape = SHAPE_SQUARE;
      CODE_SMALL_SQ: glyph.shape = SHAPE_SMALL;
      default:       glyph.shape = SHAPE_TEXT;
    endcase
  end

endmodule

// ----- rtl/bgr_geometry.sv -----
// Rectangle geometry in eighths of a pixel for one classified cell.
module bgr_geometry #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 256
) (
  input  bgr_pkg::shape_t    shape,
  input  logic [9:0]         cell_row,
  input  logic [7:0]         cell_col,
  input  logic [7:0]         block_width,
  input  logic [7:0]         block_height,
  input  logic [7:0]         padding,
  output logic               draw,
  output logic [18:0]        x_pos,
  output logic signed [21:0] y_pos,
  output logic [10:0]        rect_width,
  output logic [10:0]        rect_height
);
  import bgr_pkg::*;

  logic               in_grid;
  logic [15:0]        col_w;
  logic [17:0]        row_h;
  logic [16:0]        base_x;
  logic [18:0]        base_y;
  logic [9:0]         w2;
  logic [9:0]         w3;
  logic [9:0]         w4;
  logic [9:0]         h4;
  logic [10:0]        w6;
  logic [10:0]        w8;
  logic [10:0]        h8;
  logic [9:0]         x_off;
  logic signed [11:0] y_off;
  logic [19:0]        x_sum;
  logic signed [22:0] y_sum;
  logic [10:0]        rw;
  logic [10:0]        rh;

  assign in_grid = (17'(cell_row) < 17'(MAX_ROWS)) && (13'(cell_col) < 13'(MAX_COLS));
  assign draw    = in_grid && (shape != SHAPE_TEXT) && (shape != SHAPE_SPACE);

  // Cell origin in pixels.
  assign col_w  = 16'(cell_col) * 16'(block_width);
  assign row_h  = 18'(cell_row) * 18'(block_height);
  assign base_x = 17'(col_w) + 17'(padding);
  assign base_y = 19'(row_h) + 19'(padding);

  assign w2 = {1'b0, block_width, 1'b0};
  assign w4 = {block_width, 2'b00};
  assign w3 = 10'(block_width) + w2;
  assign h4 = {block_height, 2'b00};
  assign w6 = 11'(w4) + 11'(w2);
  assign w8 = {block_width, 3'b000};
  assign h8 = {block_height, 3'b000};

  always_comb begin
    x_off = '0;
    y_off = '0;
    rw    = w8;
    rh    = h8;
    case (shape)
      SHAPE_UPPER: rh = 11'(h4);
      SHAPE_LOWER: begin
        y_off = $signed(12'(h4));
        rh    = 11'(h4);
      end
      SHAPE_LEFT:  rw = 11'(w4);
      SHAPE_RIGHT: begin
        x_off = w4;
        rw    = 11'(w4);
      end
      SHAPE_SQUARE: begin
        x_off = 10'(block_width);
        y_off = $signed(12'(h4)) - $signed(12'(w3));
        rw    = w6;
        rh    = w6;
      end
      SHAPE_SMALL: begin
        x_off = w2;
        y_off = $signed(12'(h4)) - $signed(12'(w2));
        rw    = 11'(w4);
        rh    = 11'(w4);
      end
      default: begin
      end
    endcase
  end

  assign x_sum = {base_x, 3'b000} + 20'(x_off);
  assign y_sum = $signed({1'b0, base_y, 3'b000}) + 23'(y_off);

  assign x_pos       = draw ? x_sum[18:0] : '0;
  assign y_pos       = draw ? $signed(y_sum[21:0]) : '0;
  assign rect_width  = draw ? rw : '0;
  assign rect_height = draw ? rh : '0;

endmodule
